// File: sv/aavr_pkg.sv
// Shared types and constants for the axis-angle vector rotate core.
// Holds the request/result payload structs and the CORDIC arctangent table.
// No dependencies.
`default_nettype none

package aavr_pkg;

    // Widest CORDIC the table supports
    localparam int unsigned CordicMaxSteps = 24;
    localparam int unsigned DefCordicSteps = 16;

    // CORDIC datapath widths
    localparam int unsigned XyW = 34;
    localparam int unsigned ZW  = 33;

    // Gain-compensated starting x in Q1.30
    localparam logic signed [XyW-1:0] GainQ30 = 34'sd652032874;

    // Diagonal one in Q.28
    localparam logic signed [31:0] OneQ28 = 32'sd268435456;

    typedef struct packed {
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
        logic signed [15:0] angle;
    } request_t;

    typedef struct packed {
        logic signed [31:0] rot_x;
        logic signed [31:0] rot_y;
        logic signed [31:0] rot_z;
    } result_t;

    // atan(2^-i), 2^31 = pi
    function automatic logic signed [ZW-1:0] atan_entry(input int unsigned i);
        logic signed [ZW-1:0] t;
        begin
            unique case (i)
                0:  t = 33'sd536870912;
                1:  t = 33'sd316933406;
                2:  t = 33'sd167458907;
                3:  t = 33'sd85004756;
                4:  t = 33'sd42667331;
                5:  t = 33'sd21354465;
                6:  t = 33'sd10679838;
                7:  t = 33'sd5340245;
                8:  t = 33'sd2670163;
                9:  t = 33'sd1335087;
                10: t = 33'sd667544;
                11: t = 33'sd333772;
                12: t = 33'sd166886;
                13: t = 33'sd83443;
                14: t = 33'sd41722;
                15: t = 33'sd20861;
                16: t = 33'sd10430;
                17: t = 33'sd5215;
                18: t = 33'sd2608;
                19: t = 33'sd1304;
                20: t = 33'sd652;
                21: t = 33'sd326;
                22: t = 33'sd163;
                23: t = 33'sd81;
                default: t = '0;
            endcase
            return t;
        end
    endfunction

endpackage

`default_nettype wire

// File: sv/axis_angle_vector_rotate_core.sv
// Axis-angle vector rotation: CORDIC sine/cosine, Rodrigues matrix, matrix-vector product.
// Depends on aavr_pkg for payload structs and the arctangent table.
// Throughput: one request per cycle; busy stays low, every stage advances each cycle.
// An input register feeds one CORDIC register stage per iteration; the matrix path
// uses five register stages after it.
// Reset clears only the stage valid bits; payload registers are not reset.
`default_nettype none

module axis_angle_vector_rotate_core #(
    parameter int unsigned CORDIC_STEPS = aavr_pkg::DefCordicSteps
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  start,
    output logic                 busy,
    input  aavr_pkg::request_t   request,
    output logic                 done,
    output aavr_pkg::result_t    result
);
    import aavr_pkg::*;

    localparam int unsigned Latency = CORDIC_STEPS + 6;

    // ---------------- input stage ----------------
    logic signed [16:0]      ang_red;
    logic                    flip_next;

    // Fold angle into [-quarter, quarter] turn
    always_comb
    begin
        priority if (request.angle > 16'sd16384)
        begin
            ang_red   = 17'(request.angle) - 17'sd32768;
            flip_next = 1'b1;
        end
        else if (request.angle < -16'sd16384)
        begin
            ang_red   = 17'(request.angle) + 17'sd32768;
            flip_next = 1'b1;
        end
        else
        begin
            ang_red   = 17'(request.angle);
            flip_next = 1'b0;
        end
    end

    // ---------------- CORDIC stages ----------------
    logic                    cv_reg   [CORDIC_STEPS+1];
    logic signed [XyW-1:0]   cx_reg   [CORDIC_STEPS+1];
    logic signed [XyW-1:0]   cy_reg   [CORDIC_STEPS+1];
    logic signed [ZW-1:0]    cz_reg   [CORDIC_STEPS+1];
    logic                    cf_reg   [CORDIC_STEPS+1];
    request_t                creq_reg [CORDIC_STEPS+1];

    // Accept a request every cycle
    assign busy = 1'b0;

    // Capture the request into stage zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cv_reg[0] <= 1'b0;
        else
            cv_reg[0] <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        cx_reg[0]   <= GainQ30;
        cy_reg[0]   <= '0;
        cz_reg[0]   <= {ang_red[ZW-17:0], 16'b0};
        cf_reg[0]   <= flip_next;
        creq_reg[0] <= request;
    end

    for (genvar g = 0; g < CORDIC_STEPS; g++)
    begin : g_cordic
        logic signed [XyW-1:0] cx_next;
        logic signed [XyW-1:0] cy_next;
        logic signed [ZW-1:0]  cz_next;

        // One micro-rotation toward zero residual angle
        always_comb
        begin
            if (cz_reg[g] >= 0)
            begin
                cx_next = cx_reg[g] - (cy_reg[g] >>> g);
                cy_next = cy_reg[g] + (cx_reg[g] >>> g);
                cz_next = cz_reg[g] - atan_entry(g);
            end
            else
            begin
                cx_next = cx_reg[g] + (cy_reg[g] >>> g);
                cy_next = cy_reg[g] - (cx_reg[g] >>> g);
                cz_next = cz_reg[g] + atan_entry(g);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                cv_reg[g+1] <= 1'b0;
            else
                cv_reg[g+1] <= cv_reg[g];
        end

        always_ff @(posedge clk)
        begin
            cx_reg[g+1]   <= cx_next;
            cy_reg[g+1]   <= cy_next;
            cz_reg[g+1]   <= cz_next;
            cf_reg[g+1]   <= cf_reg[g];
            creq_reg[g+1] <= creq_reg[g];
        end
    end

    // ---------------- sin/cos rounding and axis products ----------------
    logic signed [XyW-17:0]  c_rnd;
    logic signed [XyW-17:0]  s_rnd;
    logic signed [15:0]      c_next;
    logic signed [15:0]      s_next;
    logic                    sc_valid_reg;
    logic signed [15:0]      c_reg;
    logic signed [15:0]      s_reg;
    logic signed [15:0]      u_sc   [3];
    logic signed [31:0]      v_sc   [3];
    logic signed [31:0]      p_reg  [3][3];
    logic signed [16:0]      k_reg  [3][3];
    logic signed [31:0]      v1_reg [3];
    request_t                rq;

    assign rq = creq_reg[CORDIC_STEPS];
    assign u_sc[0] = rq.axis_x;
    assign u_sc[1] = rq.axis_y;
    assign u_sc[2] = rq.axis_z;
    assign v_sc[0] = rq.vec_x;
    assign v_sc[1] = rq.vec_y;
    assign v_sc[2] = rq.vec_z;

    // Round to Q2.14, clamp to unit, undo half-turn fold
    always_comb
    begin
        logic signed [XyW-17:0] c_cl;
        logic signed [XyW-17:0] s_cl;
        c_rnd = (XyW-16)'((cx_reg[CORDIC_STEPS] + 34'sd32768) >>> 16);
        s_rnd = (XyW-16)'((cy_reg[CORDIC_STEPS] + 34'sd32768) >>> 16);
        if (c_rnd > 18'sd16384)
            c_cl = 18'sd16384;
        else if (c_rnd < -18'sd16384)
            c_cl = -18'sd16384;
        else
            c_cl = c_rnd;
        if (s_rnd > 18'sd16384)
            s_cl = 18'sd16384;
        else if (s_rnd < -18'sd16384)
            s_cl = -18'sd16384;
        else
            s_cl = s_rnd;
        if (cf_reg[CORDIC_STEPS])
        begin
            c_next = 16'(-c_cl);
            s_next = 16'(-s_cl);
        end
        else
        begin
            c_next = 16'(c_cl);
            s_next = 16'(s_cl);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sc_valid_reg <= 1'b0;
        else
            sc_valid_reg <= cv_reg[CORDIC_STEPS];
    end

    always_ff @(posedge clk)
    begin
        c_reg <= c_next;
        s_reg <= s_next;
        for (int i = 0; i < 3; i++)
        begin
            v1_reg[i] <= v_sc[i];
            for (int j = 0; j < 3; j++)
                p_reg[i][j] <= 32'(u_sc[i]) * 32'(u_sc[j]);
        end
        // Skew matrix of the axis
        k_reg[0][0] <= '0;
        k_reg[0][1] <= -17'(u_sc[2]);
        k_reg[0][2] <= 17'(u_sc[1]);
        k_reg[1][0] <= 17'(u_sc[2]);
        k_reg[1][1] <= '0;
        k_reg[1][2] <= -17'(u_sc[0]);
        k_reg[2][0] <= -17'(u_sc[1]);
        k_reg[2][1] <= 17'(u_sc[0]);
        k_reg[2][2] <= '0;
    end

    // ---------------- matrix term products ----------------
    logic                    m1_valid_reg;
    logic signed [47:0]      cm_reg  [3][3];
    logic signed [32:0]      sk_reg  [3][3];
    logic signed [31:0]      p1_reg  [3][3];
    logic signed [31:0]      v2_reg  [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m1_valid_reg <= 1'b0;
        else
            m1_valid_reg <= sc_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            v2_reg[i] <= v1_reg[i];
            for (int j = 0; j < 3; j++)
            begin
                cm_reg[i][j] <= 48'(c_reg) *
                                48'(((i == j) ? OneQ28 : 32'sd0) - p_reg[i][j]);
                sk_reg[i][j] <= 33'(s_reg) * 33'(k_reg[i][j]);
                p1_reg[i][j] <= p_reg[i][j];
            end
        end
    end

    // ---------------- matrix entries in Q.20 ----------------
    logic                    m2_valid_reg;
    logic signed [27:0]      r20_reg [3][3];
    logic signed [31:0]      v3_reg  [3];
    logic signed [27:0]      r20_next [3][3];

    // Sum the three Rodrigues terms and round to Q.20
    always_comb
    begin
        logic signed [35:0] r28;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                r28 = 36'(p1_reg[i][j])
                    + 36'((cm_reg[i][j] + 48'sd8192) >>> 14)
                    + 36'(sk_reg[i][j]);
                r20_next[i][j] = 28'((r28 + 36'sd128) >>> 8);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m2_valid_reg <= 1'b0;
        else
            m2_valid_reg <= m1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        r20_reg <= r20_next;
        v3_reg  <= v2_reg;
    end

    // ---------------- matrix-vector products ----------------
    logic                    m3_valid_reg;
    logic signed [59:0]      mv_reg [3][3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m3_valid_reg <= 1'b0;
        else
            m3_valid_reg <= m2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                mv_reg[i][j] <= 60'(r20_reg[i][j]) * 60'(v3_reg[j]);
    end

    // ---------------- accumulate, round, saturate ----------------
    logic                    out_valid_reg;
    logic signed [31:0]      rot_next [3];
    result_t                 result_reg;

    always_comb
    begin
        logic signed [61:0] acc;
        logic signed [41:0] sh;
        for (int i = 0; i < 3; i++)
        begin
            acc = 62'(mv_reg[i][0]) + 62'(mv_reg[i][1]) + 62'(mv_reg[i][2])
                + 62'sd524288;
            sh  = 42'(acc >>> 20);
            if (sh > 42'sd2147483647)
                rot_next[i] = 32'sh7FFFFFFF;
            else if (sh < -42'sd2147483648)
                rot_next[i] = 32'sh80000000;
            else
                rot_next[i] = 32'(sh);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= m3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        result_reg.rot_x <= rot_next[0];
        result_reg.rot_y <= rot_next[1];
        result_reg.rot_z <= rot_next[2];
    end

    assign done   = out_valid_reg;
    assign result = result_reg;

    // ---------------- checks ----------------
    // Every result traces back to a request exactly one latency earlier
    a_done_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, Latency))
        else $error("done without matching request");

    // Rounded cosine and sine stay within unit magnitude
    a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
        sc_valid_reg |-> (c_reg <= 16'sd16384) && (c_reg >= -16'sd16384)
                         && (s_reg <= 16'sd16384) && (s_reg >= -16'sd16384))
        else $error("sin/cos out of range");

endmodule

`default_nettype wire
